@@ hw/rtl/plre_pkg.sv @@
// ----------------------------------------------------------------------------
// plre_pkg
// Shared types and constants of the polyline map record encoder.
// ----------------------------------------------------------------------------
package plre_pkg;

	localparam int LON_W  = 22;
	localparam int LAT_W  = 21;
	localparam int CODE_W = 24;
	localparam int LATC_W = 21;
	localparam int PT_W   = CODE_W + LATC_W;
	localparam int LVL_W  = 8;
	localparam int CNT_W  = 8;

	localparam logic [CODE_W-1:0]       LON_OFFSET = 24'd3600000;
	localparam logic [LATC_W-1:0]       LAT_OFFSET = 21'd900000;
	localparam logic signed [LAT_W-1:0] LAT_MAX    = 21'sd900000;
	localparam logic signed [LAT_W-1:0] LAT_MIN    = -21'sd900000;

	typedef enum logic [1:0] {
		OP_CONT  = 2'd0,
		OP_NEW   = 2'd1,
		OP_FLUSH = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HDR,
		S_RD,
		S_PNT,
		S_ONE_HDR,
		S_ONE_PNT
	} state_t;

	typedef enum logic [1:0] {
		TAIL_CLEAR,
		TAIL_PUSH,
		TAIL_CARRY
	} tail_t;

	typedef struct packed {
		logic wr_plain;
		logic wr_new_in;
		logic clr_fill;
		logic latch_item;
		logic push_item;
		logic carry;
		logic idx_clr;
		logic rd_pnt;
		logic ld_hdr;
		logic ld_pnt;
		logic ld_one_hdr;
		logic ld_one_pnt;
		logic out_last;
	} ctrl_cmd_t;

	typedef struct packed {
		logic fill_zero;
		logic fill_ge2;
		logic fill_next_full;
		logic neg_in;
		logic first_neg;
		logic idx_last;
		logic out_free;
	} ctrl_stat_t;

endpackage

@@ hw/rtl/polyline_map_record_encoder.sv @@
// ----------------------------------------------------------------------------
// polyline_map_record_encoder
// Buffers polyline points one segment at a time and emits map records.
// ----------------------------------------------------------------------------
// A point that only extends the buffered segment is written to the segment RAM
// and gives no result. A request that closes a segment then emits its record:
// first the header, then each point, which is read from the segment RAM
// (registered read) before it is loaded into the result register. A sign
// change adds a one-point record: its header, then its point.
// Results wait in a single output register, and a stall there holds the
// sequence. New requests are taken again once the last result is loaded.
// The segment RAM needs no clearing after reset.
module polyline_map_record_encoder
	import plre_pkg::*;
#(
	parameter int MAX_POINTS = 62
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              op,
	input  logic signed [LON_W-1:0] longitude,
	input  logic signed [LAT_W-1:0] latitude,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [LVL_W-1:0]        cfg_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    is_point,
	output logic [LVL_W-1:0]        record_level,
	output logic [CNT_W-1:0]        point_count,
	output logic [CODE_W-1:0]       lon_code,
	output logic [CODE_W-1:0]       lat_code,
	output logic                    last_of_run
);

	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;

	assign cfg_ready = 1'b1;

	plre_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op      (op),
		.stat    (stat),
		.cmd     (cmd)
	);

	plre_dp #(
		.MAX_POINTS(MAX_POINTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.longitude   (longitude),
		.latitude    (latitude),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.stat        (stat),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.is_point    (is_point),
		.record_level(record_level),
		.point_count (point_count),
		.lon_code    (lon_code),
		.lat_code    (lat_code),
		.last_of_run (last_of_run)
	);

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ld_hdr || cmd.ld_pnt || cmd.ld_one_hdr || cmd.ld_one_pnt) |-> stat.out_free)
		else $error("result loaded over a pending result");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wr_plain, cmd.wr_new_in, cmd.push_item, cmd.carry}))
		else $error("segment RAM written by two sources");

	a_header_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_point) |-> (point_count != '0 &&
			point_count <= CNT_W'(MAX_POINTS)))
		else $error("header point count out of range");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ld_hdr || cmd.ld_one_hdr) |-> !in_ready)
		else $error("request taken while a record is emitted");

endmodule

@@ hw/rtl/plre_ram.sv @@
// ----------------------------------------------------------------------------
// plre_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module plre_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/plre_ctrl.sv @@
// ----------------------------------------------------------------------------
// plre_ctrl
// Sequencer: decodes each request, then walks header and point emission.
// ----------------------------------------------------------------------------
module plre_ctrl
	import plre_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] op,
	input  ctrl_stat_t stat,
	output ctrl_cmd_t  cmd
);

	state_t state_q, state_d;
	tail_t  tail_q, tail_d;
	logic   single_q, single_d;

	logic acc;
	logic is_pt_op;
	logic start_new;
	logic sign_chg;
	logic dec_seg;
	logic dec_one;
	tail_t dec_tail;
	logic dec_single;

	assign acc      = (state_q == S_IDLE) && in_valid;
	assign is_pt_op = (op == OP_CONT) || (op == OP_NEW);
	assign start_new = is_pt_op && ((op == OP_NEW) || stat.fill_zero);
	assign sign_chg  = is_pt_op && !start_new && (stat.neg_in != stat.first_neg);

	always_comb begin
		dec_seg    = 1'b0;
		dec_one    = 1'b0;
		dec_single = 1'b0;
		dec_tail   = TAIL_CLEAR;
		if (op == OP_FLUSH) begin
			dec_seg = stat.fill_ge2;
		end else if (start_new) begin
			dec_seg  = stat.fill_ge2;
			dec_tail = TAIL_PUSH;
		end else if (sign_chg) begin
			dec_seg    = stat.fill_ge2;
			dec_one    = !stat.fill_ge2;
			dec_single = 1'b1;
			dec_tail   = TAIL_PUSH;
		end else if (is_pt_op) begin
			dec_seg  = stat.fill_next_full;
			dec_tail = TAIL_CARRY;
		end
	end

	always_comb begin
		state_d  = state_q;
		tail_d   = tail_q;
		single_d = single_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					tail_d   = dec_tail;
					single_d = dec_single;
					if (dec_seg) begin
						state_d = S_HDR;
					end else if (dec_one) begin
						state_d = S_ONE_HDR;
					end
				end
			end
			S_HDR: begin
				if (stat.out_free) begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				state_d = S_PNT;
			end
			S_PNT: begin
				if (stat.out_free) begin
					if (!stat.idx_last) begin
						state_d = S_RD;
					end else if (single_q) begin
						state_d = S_ONE_HDR;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_ONE_HDR: begin
				if (stat.out_free) begin
					state_d = S_ONE_PNT;
				end
			end
			S_ONE_PNT: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		logic tail_go;
		tail_go  = 1'b0;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (acc) begin
					if (op == OP_FLUSH) begin
						cmd.clr_fill = !stat.fill_ge2;
					end else if (start_new) begin
						cmd.wr_new_in  = !stat.fill_ge2;
						cmd.latch_item = stat.fill_ge2;
					end else if (sign_chg) begin
						cmd.latch_item = 1'b1;
					end else if (is_pt_op) begin
						cmd.wr_plain = 1'b1;
					end
				end
			end
			S_HDR: begin
				cmd.ld_hdr  = stat.out_free;
				cmd.idx_clr = stat.out_free;
			end
			S_RD: begin
				cmd.rd_pnt = 1'b1;
			end
			S_PNT: begin
				cmd.ld_pnt   = stat.out_free;
				cmd.out_last = stat.idx_last && !single_q;
				tail_go      = stat.out_free && stat.idx_last && !single_q;
			end
			S_ONE_HDR: begin
				cmd.ld_one_hdr = stat.out_free;
			end
			S_ONE_PNT: begin
				cmd.ld_one_pnt = stat.out_free;
				cmd.out_last   = 1'b1;
				tail_go        = stat.out_free;
			end
			default: begin
			end
		endcase
		if (tail_go) begin
			case (tail_q)
				TAIL_CLEAR: cmd.clr_fill  = 1'b1;
				TAIL_PUSH:  cmd.push_item = 1'b1;
				TAIL_CARRY: cmd.carry     = 1'b1;
				default:    cmd.clr_fill  = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			tail_q   <= TAIL_CLEAR;
			single_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			tail_q   <= tail_d;
			single_q <= single_d;
		end
	end

endmodule

@@ hw/rtl/plre_dp.sv @@
// ----------------------------------------------------------------------------
// plre_dp
// Datapath: point coding, segment buffer, fill tracking and result register.
// ----------------------------------------------------------------------------
module plre_dp
	import plre_pkg::*;
#(
	parameter int MAX_POINTS = 62
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [LON_W-1:0] longitude,
	input  logic signed [LAT_W-1:0] latitude,
	input  logic                    cfg_valid,
	input  logic [LVL_W-1:0]        cfg_data,
	input  ctrl_cmd_t               cmd,
	output ctrl_stat_t              stat,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic                    is_point,
	output logic [LVL_W-1:0]        record_level,
	output logic [CNT_W-1:0]        point_count,
	output logic [CODE_W-1:0]       lon_code,
	output logic [CODE_W-1:0]       lat_code,
	output logic                    last_of_run
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int FW = $clog2(MAX_POINTS + 1);

	logic [LVL_W-1:0] level_q;
	logic [FW-1:0]    fill_q;
	logic             first_neg_q;
	logic [PT_W-1:0]  last_pt_q;
	logic [PT_W-1:0]  item_q;
	logic             item_neg_q;
	logic [AW-1:0]    idx_q;
	logic             out_valid_q;

	logic                    neg_in;
	logic [CODE_W-1:0]       lon_ext;
	logic [CODE_W-1:0]       lon_c;
	logic signed [LAT_W-1:0] lat_sat;
	logic [LATC_W-1:0]       lat_c;
	logic [PT_W-1:0]         packed_in;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [PT_W-1:0] ram_wdata;
	logic [PT_W-1:0] ram_rdata;
	logic            out_free;
	logic            out_load;

	assign neg_in  = longitude[LON_W-1];
	assign lon_ext = CODE_W'(longitude);
	assign lon_c   = neg_in ? lon_ext + LON_OFFSET : lon_ext;

	always_comb begin
		if (latitude < LAT_MIN) begin
			lat_sat = LAT_MIN;
		end else if (latitude > LAT_MAX) begin
			lat_sat = LAT_MAX;
		end else begin
			lat_sat = latitude;
		end
	end

	assign lat_c     = $unsigned(lat_sat) + LAT_OFFSET;
	assign packed_in = {lon_c, lat_c};

	assign ram_we    = cmd.wr_plain | cmd.wr_new_in | cmd.push_item | cmd.carry;
	assign ram_waddr = cmd.wr_plain ? fill_q[AW-1:0] : '0;
	always_comb begin
		if (cmd.wr_plain || cmd.wr_new_in) begin
			ram_wdata = packed_in;
		end else if (cmd.push_item) begin
			ram_wdata = item_q;
		end else begin
			ram_wdata = last_pt_q;
		end
	end

	plre_ram #(
		.WIDTH(PT_W),
		.DEPTH(MAX_POINTS)
	) u_seg_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.rd_pnt),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= '0;
			fill_q      <= '0;
			first_neg_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				level_q <= cfg_data;
			end
			if (cmd.wr_plain) begin
				fill_q <= fill_q + 1'b1;
			end else if (cmd.clr_fill) begin
				fill_q <= '0;
			end else if (cmd.wr_new_in || cmd.push_item || cmd.carry) begin
				fill_q <= FW'(1);
			end
			if (cmd.wr_new_in) begin
				first_neg_q <= neg_in;
			end else if (cmd.push_item) begin
				first_neg_q <= item_neg_q;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_item) begin
			item_q     <= packed_in;
			item_neg_q <= neg_in;
		end
		if (cmd.wr_plain || cmd.wr_new_in) begin
			last_pt_q <= packed_in;
		end else if (cmd.push_item) begin
			last_pt_q <= item_q;
		end
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.ld_pnt) begin
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.ld_hdr || cmd.ld_one_hdr) begin
			is_point     <= 1'b0;
			record_level <= level_q;
			point_count  <= cmd.ld_hdr ? CNT_W'(fill_q) : CNT_W'(1);
			lon_code     <= '0;
			lat_code     <= '0;
			last_of_run  <= 1'b0;
		end else if (cmd.ld_pnt || cmd.ld_one_pnt) begin
			is_point     <= 1'b1;
			record_level <= '0;
			point_count  <= '0;
			lon_code     <= cmd.ld_pnt ? ram_rdata[PT_W-1:LATC_W] : last_pt_q[PT_W-1:LATC_W];
			lat_code     <= CODE_W'(cmd.ld_pnt ? ram_rdata[LATC_W-1:0]
				: last_pt_q[LATC_W-1:0]);
			last_of_run  <= cmd.out_last;
		end
	end

	assign out_load  = cmd.ld_hdr | cmd.ld_one_hdr | cmd.ld_pnt | cmd.ld_one_pnt;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	assign stat.fill_zero      = (fill_q == '0);
	assign stat.fill_ge2       = (fill_q > FW'(1));
	assign stat.fill_next_full = (fill_q == FW'(MAX_POINTS - 1));
	assign stat.neg_in         = neg_in;
	assign stat.first_neg      = first_neg_q;
	assign stat.idx_last       = ((FW'(idx_q) + 1'b1) == fill_q);
	assign stat.out_free       = out_free;

endmodule

@@ bench/polyline_map_record_encoder_tb.sv @@
// ----------------------------------------------------------------------------
// polyline_map_record_encoder_tb
// Drives polyline points, new-path and flush requests into the encoder and
// checks every record header and point item against a predictor that keeps
// its own copy of the open segment. A directed table covers coordinate
// extremes, saturation, sign changes and short segments; random paths with
// random gaps and stalls on both channels follow, under several level bytes.
// ----------------------------------------------------------------------------
module polyline_map_record_encoder_tb
	import plre_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SEG_MAX = 62;
	localparam int SETTLE  = 8;
	localparam int UNTYPED = -1;
	localparam int DIR_N   = 23;

	typedef struct packed {
		logic              is_point;
		logic [LVL_W-1:0]  level;
		logic [CNT_W-1:0]  count;
		logic [CODE_W-1:0] lon;
		logic [CODE_W-1:0] lat;
		logic              last;
	} rec_t;

	typedef struct packed {
		logic [CODE_W-1:0] lon;
		logic [CODE_W-1:0] lat;
	} pt_t;

	typedef struct packed {
		op_t op;
		int  lon;
		int  lat;
		int  want_n;
		int  want_lon;
		int  want_lat;
	} dir_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	op_t                     op = OP_CONT;
	logic signed [LON_W-1:0] longitude = '0;
	logic signed [LAT_W-1:0] latitude = '0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [LVL_W-1:0]        cfg_data = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic                    is_point;
	logic [LVL_W-1:0]        record_level;
	logic [CNT_W-1:0]        point_count;
	logic [CODE_W-1:0]       lon_code;
	logic [CODE_W-1:0]       lat_code;
	logic                    last_of_run;

	// predictor state
	pt_t              open_seg [SEG_MAX];
	int               open_fill = 0;
	bit               open_neg = 1'b0;
	logic [LVL_W-1:0] level_byte = '0;
	pt_t              coded_pt;
	rec_t             pending_items [$];

	int  chk_count = UNTYPED;
	int  chk_lon = UNTYPED;
	int  chk_lat = UNTYPED;
	bit  steady = 1'b0;
	int  errors = 0;
	int  n_sent = 0;
	int  n_results = 0;
	int  n_records = 0;
	int  n_full = 0;
	int  n_sign = 0;
	int  n_level = 0;

	dir_row_t dir_rows [DIR_N] = '{
		'{OP_CONT,   100,      200,      0, 100,      900200},
		'{OP_CONT,   0,        -900000,  0, 0,        0},
		'{OP_CONT,   1800000,  900000,   0, 1800000,  1800000},
		'{OP_CONT,   -1,       5,        6, 3599999,  900005},
		'{OP_CONT,   -1800000, 1048575,  0, 1800000,  1800000},
		'{OP_CONT,   7,        -1048576, 5, 7,        0},
		'{OP_CONT,   0,        0,        0, UNTYPED,  UNTYPED},
		'{OP_NEW,    -2097152, 0,        3, 1502848,  900000},
		'{OP_CONT,   2097151,  1,        2, 2097151,  900001},
		'{OP_NEW,    5,        5,        0, UNTYPED,  UNTYPED},
		'{OP_FLUSH,  123,      456,      0, UNTYPED,  UNTYPED},
		'{OP_FLUSH,  0,        0,        0, UNTYPED,  UNTYPED},
		'{OP_NONE,   -5,       -5,       0, UNTYPED,  UNTYPED},
		'{OP_CONT,   -300,     400,      0, UNTYPED,  UNTYPED},
		'{OP_CONT,   -301,     401,      0, UNTYPED,  UNTYPED},
		'{OP_FLUSH,  0,        0,        3, UNTYPED,  UNTYPED},
		'{OP_NEW,    10,       10,       0, UNTYPED,  UNTYPED},
		'{OP_NEW,    11,       11,       0, UNTYPED,  UNTYPED},
		'{OP_CONT,   12,       12,       0, UNTYPED,  UNTYPED},
		'{OP_NEW,    -12,      -12,      3, UNTYPED,  UNTYPED},
		'{OP_CONT,   -13,      900001,   0, 3599987,  1800000},
		'{OP_CONT,   14,       -900001,  5, 14,       0},
		'{OP_FLUSH,  0,        0,        0, UNTYPED,  UNTYPED}
	};

	polyline_map_record_encoder #(
		.MAX_POINTS(SEG_MAX)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.longitude(longitude),
		.latitude(latitude),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.is_point(is_point),
		.record_level(record_level),
		.point_count(point_count),
		.lon_code(lon_code),
		.lat_code(lat_code),
		.last_of_run(last_of_run)
	);

	always #2 clk = ~clk;

	function automatic void put_header(int cnt);
		rec_t r;
		r = '0;
		r.level = level_byte;
		r.count = CNT_W'(cnt);
		pending_items.insert(pending_items.size(), r);
	endfunction

	function automatic void put_point(pt_t p);
		rec_t r;
		r = '0;
		r.is_point = 1'b1;
		r.lon = p.lon;
		r.lat = p.lat;
		pending_items.insert(pending_items.size(), r);
	endfunction

	function automatic void put_segment();
		put_header(open_fill);
		for (int i = 0; i < open_fill; i++)
			put_point(open_seg[i]);
	endfunction

	function automatic void open_point(pt_t p, bit neg);
		if (open_fill == 0)
			open_neg = neg;
		open_seg[open_fill] = p;
		open_fill++;
	endfunction

	function automatic int encode_request(op_t o, logic signed [LON_W-1:0] lon,
			logic signed [LAT_W-1:0] lat);
		int   first;
		int   lon_v;
		int   lat_v;
		bit   neg;
		pt_t  p;
		first = pending_items.size();
		if (o == OP_NONE)
			return 0;
		if (o == OP_FLUSH) begin
			if (open_fill >= 2)
				put_segment();
			open_fill = 0;
		end else begin
			lon_v = int'(lon);
			lat_v = int'(lat);
			if (lat_v > int'(LAT_MAX))
				lat_v = int'(LAT_MAX);
			if (lat_v < int'(LAT_MIN))
				lat_v = int'(LAT_MIN);
			neg = lon_v < 0;
			p.lon = CODE_W'(neg ? lon_v + int'(LON_OFFSET) : lon_v);
			p.lat = CODE_W'(lat_v + int'(LAT_OFFSET));
			coded_pt = p;
			if (o == OP_NEW || open_fill == 0) begin
				if (open_fill >= 2)
					put_segment();
				open_fill = 0;
				open_point(p, neg);
			end else if (neg != open_neg) begin
				if (open_fill >= 2)
					put_segment();
				put_header(1);
				put_point(open_seg[open_fill-1]);
				open_fill = 0;
				open_point(p, neg);
				n_sign++;
			end else begin
				open_point(p, neg);
				if (open_fill >= SEG_MAX) begin
					put_segment();
					open_seg[0] = open_seg[SEG_MAX-1];
					open_fill = 1;
					n_full++;
				end
			end
		end
		if (pending_items.size() > first)
			pending_items[pending_items.size()-1].last = 1'b1;
		return pending_items.size() - first;
	endfunction

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : scoreboard
		rec_t want;
		int   n;
		if (cfg_valid && cfg_ready) begin
			level_byte = cfg_data;
			n_level++;
		end
		if (in_valid && in_ready) begin
			n = encode_request(op, longitude, latitude);
			if (chk_count != UNTYPED)
				check_field("result count", chk_count, n);
			if (chk_lon != UNTYPED)
				check_field("typed lon_code", chk_lon, coded_pt.lon);
			if (chk_lat != UNTYPED)
				check_field("typed lat_code", chk_lat, coded_pt.lat);
		end
		if (out_valid && out_ready) begin
			n_results++;
			if (!is_point)
				n_records++;
			if (pending_items.size() == 0) begin
				$error("unexpected result: is_point %0b lon 0x%0h lat 0x%0h",
					is_point, lon_code, lat_code);
				errors++;
			end else begin
				want = pending_items.pop_front();
				check_field("is_point", want.is_point, is_point);
				check_field("record_level", want.level, record_level);
				check_field("point_count", want.count, point_count);
				check_field("lon_code", want.lon, lon_code);
				check_field("lat_code", want.lat, lat_code);
				check_field("last_of_run", want.last, last_of_run);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 20);
	endfunction

	initial begin : result_stalls
		int g;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			g = pick_gap();
			if (g > 0 && !steady) begin
				out_ready <= 1'b0;
				repeat (g) @(negedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	end

	// entered and left at a falling edge
	task automatic send_request(op_t o, int lon, int lat, int wn = UNTYPED,
			int wl = UNTYPED, int wa = UNTYPED);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		op <= o;
		longitude <= LON_W'(lon);
		latitude <= LAT_W'(lat);
		in_valid <= 1'b1;
		chk_count = wn;
		chk_lon = wl;
		chk_lat = wa;
		if (o != OP_NONE)
			n_sent++;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		while (pending_items.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_level(logic [LVL_W-1:0] v);
		in_valid <= 1'b0;
		wait_idle();
		repeat (SETTLE) @(negedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic int rand_lon(bit neg);
		int r;
		int mag;
		r = $urandom_range(0, 99);
		if (r < 6)
			return 0;
		if (r < 12)
			return $urandom();
		mag = $urandom_range(1, 1800000);
		return neg ? -mag : mag;
	endfunction

	function automatic int rand_lat();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return $urandom();
		if (r < 12)
			return $urandom_range(0, 1) ? $urandom_range(900001, 1048575)
				: -$urandom_range(900001, 1048576);
		return $urandom_range(0, 1800000) - 900000;
	endfunction

	task automatic run_path(int len, int flip_pct);
		bit neg;
		neg = $urandom_range(0, 1);
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(0, 99) < flip_pct)
				neg = !neg;
			send_request((k == 0 && $urandom_range(0, 3) != 0) ? OP_NEW : OP_CONT,
				rand_lon(neg), rand_lat());
		end
	endtask

	task automatic random_paths(int quota);
		int start;
		int r;
		start = n_sent;
		while (n_sent - start < quota) begin
			steady = $urandom_range(0, 5) == 0;
			run_path(($urandom_range(0, 11) == 0) ? $urandom_range(20, 70)
				: $urandom_range(1, 8), 8);
			r = $urandom_range(0, 99);
			if (r < 25)
				send_request(OP_FLUSH, $urandom(), $urandom());
			else if (r < 35)
				send_request(op_t'($urandom_range(0, 3)), $urandom(), $urandom());
			else if (r < 42) begin
				in_valid <= 1'b0;
				wait_idle();
			end
		end
		steady = 1'b0;
	endtask

	initial begin : stimulus
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (dir_rows[i])
			send_request(dir_rows[i].op, dir_rows[i].lon, dir_rows[i].lat,
				dir_rows[i].want_n, dir_rows[i].want_lon, dir_rows[i].want_lat);
		write_level(8'hFF);
		run_path(SEG_MAX + 3, 0);
		random_paths(15);
		write_level(LVL_W'($urandom_range(1, 254)));
		random_paths(15);
		write_level(8'h00);
		random_paths(15);
		in_valid <= 1'b0;
		wait_idle();
		repeat (2 * SETTLE) @(negedge clk);
		$display("covered %0d point/flush requests, %0d results in %0d records",
			n_sent, n_results, n_records);
		$display("%0d full segments, %0d sign changes, %0d level byte writes",
			n_full, n_sign, n_level);
		if (errors == 0)
			$display("polyline_map_record_encoder_tb OK");
		else
			$display("polyline_map_record_encoder_tb NOT OK");
		$finish;
	end

	initial begin : watchdog
		#5ms;
		$display("timeout with %0d results outstanding", pending_items.size());
		$display("polyline_map_record_encoder_tb NOT OK");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/plre_pkg.sv
hw/rtl/plre_ram.sv
hw/rtl/plre_ctrl.sv
hw/rtl/plre_dp.sv
hw/rtl/polyline_map_record_encoder.sv
bench/polyline_map_record_encoder_tb.sv
